// ===== rtl/csmp_pkg.sv =====
// Package: types and constants for the classic STUN message parser.
`default_nettype none
package csmp_pkg;
    localparam int unsigned HDR_BYTES = 20;
    localparam logic [16:0] OFFSET_LIMIT = 17'h1FFFF;
    localparam logic [15:0] TYPE_TOP_BITS = 16'hC000;
    localparam logic [31:0] NEW_STUN_COOKIE = 32'h2112a442;
    localparam logic [31:0] XMCP_COOKIE = 32'h7f5a9bc7;
    localparam logic [15:0] XOR_MAPPED_TYPE = 16'h8020;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_SHORT    = 3'd1,
        VERDICT_NOT_CLS  = 3'd2,
        VERDICT_UNKNOWN  = 3'd3,
        VERDICT_LEN_MISM = 3'd4,
        VERDICT_BOGUS    = 3'd5
    } verdict_t;

    typedef struct packed {
        logic        last_of_run;
        logic [2:0]  verdict;
        logic [5:0]  present_mask;
        logic [7:0]  err_number;
        logic [2:0]  err_class;
        logic [31:0] word_value;
        logic [31:0] ipv4_clear;
        logic [15:0] port_clear;
        logic [7:0]  addr_family;
        logic [15:0] attr_len;
        logic [15:0] type_code;
        logic        record_kind;
    } record_t;

    function automatic logic type_known(input logic [15:0] t);
        case (t)
            16'h0001, 16'h0101, 16'h0111, 16'h0002, 16'h0102, 16'h0112,
            16'h0003, 16'h0103, 16'h0113, 16'h0004, 16'h0104, 16'h0114,
            16'h0115, 16'h0006, 16'h0106, 16'h0116: type_known = 1'b1;
            default: type_known = 1'b0;
        endcase
    endfunction

    function automatic logic [5:0] presence(input logic [15:0] t,
                                            input logic [15:0] len,
                                            input logic [7:0] fam);
        logic [5:0] m;
        m = '0;
        case (t)
            16'h0001, 16'h0002, 16'h0004, 16'h0005, 16'h000b, 16'h000e,
            16'h0011, 16'h0012, XOR_MAPPED_TYPE: begin
                m[0] = len >= 16'd2;
                m[1] = len >= 16'd4;
                m[2] = (len >= 16'd8) && (fam == 8'd1);
            end
            16'h0016: m[0] = len >= 16'd2;
            16'h0003, 16'h000d, 16'h000f, 16'h0010: m[3] = len >= 16'd4;
            16'h0009: begin
                m[4] = len >= 16'd3;
                m[5] = len >= 16'd4;
            end
            default: m = '0;
        endcase
        presence = m;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/classic_stun_message_parser.sv =====
// Top level: classic STUN message parser, one message byte per item.
//  channel | dir | tdata                | tuser | tlast
//  s_      | in  | data_byte            | -     | end_of_message
//  m_      | out | record fields (below)| -     | last_of_run
// One byte accepted per cycle while no record waits; records appear the cycle after.
// Each byte gives up to two records (attribute record, then verdict) into a
// two-entry queue; s_tready is high while the queue is empty or its last
// record leaves in that cycle, so after a two-record byte the next byte waits for a pop.
// Synchronous active-low reset clears all parse state and the queue.
`default_nettype none
module classic_stun_message_parser (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // data_byte
    input  wire          s_tlast,   // end_of_message
    output logic         m_tvalid,
    input  wire          m_tready,
    // record_kind, type_code, attr_len, addr_family, port_clear, ipv4_clear,
    // word_value, err_class, err_number, present_mask, verdict; pad to 144
    output logic [143:0] m_tdata,
    output logic         m_tlast    // last_of_run
);
    logic [16:0] byte_offset_reg;
    logic [15:0] hdr_type_reg, len_left_reg, decl_len_reg;
    logic [31:0] txn_word_reg;
    logic [15:0] attr_idx_reg, attr_type_reg, attr_len_reg;
    logic [31:0] cap_fields_reg, cap_word_reg;
    logic [2:0]  reject_reg;

    csmp_pkg::record_t q_reg [2];
    logic [1:0] q_count_reg;
    logic       q_rd_reg;

    logic accept, pop;
    assign s_tready = (q_count_reg == 2'd0) || (q_count_reg == 2'd1 && m_tready);
    assign accept = s_tvalid && s_tready;
    assign m_tvalid = q_count_reg != 2'd0;
    assign pop = m_tvalid && m_tready;

    // next-state
    logic [16:0] off_n;
    logic [15:0] mt_n, left_n, dl_n, idx_n, at_n, al_n;
    logic [31:0] tw_n, cf_n, cw_n;
    logic [2:0]  rj_n;
    csmp_pkg::record_t attr_rec, verd_rec;
    logic attr_emit;
    logic [7:0] b;
    logic [7:0] fam;
    logic [15:0] port;
    logic [31:0] ip;
    logic [5:0] m;
    logic bogus;
    logic [2:0] v;
    logic [1:0] k;
    logic [15:0] idx_inc;

    always_comb begin
        b = s_tdata;
        off_n = byte_offset_reg; mt_n = hdr_type_reg; left_n = len_left_reg;
        dl_n = decl_len_reg; tw_n = txn_word_reg; idx_n = attr_idx_reg;
        at_n = attr_type_reg; al_n = attr_len_reg; cf_n = cap_fields_reg;
        cw_n = cap_word_reg; rj_n = reject_reg;
        attr_emit = 1'b0; bogus = 1'b0;
        idx_inc = attr_idx_reg + 16'd1;
        k = attr_idx_reg[1:0];
        if (byte_offset_reg < 17'(csmp_pkg::HDR_BYTES)) begin
            if (byte_offset_reg < 17'd2) mt_n = {hdr_type_reg[7:0], b};
            else if (byte_offset_reg < 17'd4) dl_n = {decl_len_reg[7:0], b};
            else if (byte_offset_reg < 17'd8) tw_n = {txn_word_reg[23:0], b};
            if (byte_offset_reg == 17'(csmp_pkg::HDR_BYTES - 1)) begin
                if ((hdr_type_reg & csmp_pkg::TYPE_TOP_BITS) != 16'd0
                    || txn_word_reg == csmp_pkg::NEW_STUN_COOKIE
                    || txn_word_reg == csmp_pkg::XMCP_COOKIE)
                    rj_n = csmp_pkg::VERDICT_NOT_CLS;
                else if (!csmp_pkg::type_known(hdr_type_reg))
                    rj_n = csmp_pkg::VERDICT_UNKNOWN;
                left_n = decl_len_reg;
            end
        end else if (reject_reg == csmp_pkg::VERDICT_OK && len_left_reg != 16'd0) begin
            if (attr_idx_reg == 16'd0 && len_left_reg < 16'd4) begin
                rj_n = csmp_pkg::VERDICT_BOGUS;
            end else if (attr_idx_reg == 16'd3
                         && {attr_len_reg[15:8], b} >= len_left_reg) begin
                al_n = {attr_len_reg[15:8], b};
                attr_emit = 1'b1; bogus = 1'b1;
                rj_n = csmp_pkg::VERDICT_BOGUS;
                idx_n = '0;
            end else begin
                if (attr_idx_reg == 16'd0) begin
                    at_n = {b, 8'd0}; al_n = '0; cw_n = '0; cf_n = '0;
                end else if (attr_idx_reg == 16'd1) at_n = {attr_type_reg[15:8], b};
                else if (attr_idx_reg == 16'd2) al_n = {b, 8'd0};
                else if (attr_idx_reg == 16'd3) al_n = {attr_len_reg[15:8], b};
                else if (attr_idx_reg < 16'd8) begin
                    case (k)
                        2'd0: cw_n[31:24] = b;
                        2'd1: cw_n[23:16] = b;
                        2'd2: cw_n[15:8] = b;
                        default: cw_n[7:0] = b;
                    endcase
                end else if (attr_idx_reg < 16'd12) begin
                    case (k)
                        2'd0: cf_n[31:24] = b;
                        2'd1: cf_n[23:16] = b;
                        2'd2: cf_n[15:8] = b;
                        default: cf_n[7:0] = b;
                    endcase
                end
                left_n = len_left_reg - 16'd1;
                idx_n = idx_inc;
                if (attr_idx_reg >= 16'd3 && {1'b0, idx_inc} == 17'd4 + {1'b0, al_n}) begin
                    attr_emit = 1'b1; idx_n = '0;
                end
            end
        end
        if (byte_offset_reg < csmp_pkg::OFFSET_LIMIT) off_n = byte_offset_reg + 17'd1;

        fam = cw_n[23:16];
        port = cw_n[15:0];
        ip = cf_n;
        if (at_n == csmp_pkg::XOR_MAPPED_TYPE) begin
            port = port ^ txn_word_reg[31:16];
            ip = ip ^ txn_word_reg;
        end
        m = bogus ? 6'd0 : csmp_pkg::presence(at_n, al_n, fam);
        attr_rec = '0;
        attr_rec.type_code = at_n;
        attr_rec.attr_len = al_n;
        attr_rec.addr_family = m[0] ? fam : 8'd0;
        attr_rec.port_clear = m[1] ? port : 16'd0;
        attr_rec.ipv4_clear = m[2] ? ip : 32'd0;
        attr_rec.word_value = m[3] ? cw_n : 32'd0;
        attr_rec.err_class = m[4] ? cw_n[10:8] : 3'd0;
        attr_rec.err_number = m[5] ? cw_n[7:0] : 8'd0;
        attr_rec.present_mask = m;
        attr_rec.last_of_run = !s_tlast;

        if (off_n < 17'(csmp_pkg::HDR_BYTES)) v = csmp_pkg::VERDICT_SHORT;
        else if (rj_n == csmp_pkg::VERDICT_NOT_CLS || rj_n == csmp_pkg::VERDICT_UNKNOWN)
            v = rj_n;
        else if (off_n != 17'(csmp_pkg::HDR_BYTES) + {1'b0, dl_n})
            v = csmp_pkg::VERDICT_LEN_MISM;
        else v = rj_n;
        verd_rec = '0;
        verd_rec.record_kind = 1'b1;
        verd_rec.type_code = mt_n;
        verd_rec.verdict = v;
        verd_rec.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_offset_reg <= '0; hdr_type_reg <= '0; len_left_reg <= '0;
            decl_len_reg <= '0; txn_word_reg <= '0; attr_idx_reg <= '0;
            attr_type_reg <= '0; attr_len_reg <= '0; cap_fields_reg <= '0;
            cap_word_reg <= '0; reject_reg <= '0;
            q_count_reg <= '0; q_rd_reg <= 1'b0;
        end else begin
            if (accept) begin
                if (s_tlast) begin
                    byte_offset_reg <= '0; hdr_type_reg <= '0; len_left_reg <= '0;
                    decl_len_reg <= '0; txn_word_reg <= '0; attr_idx_reg <= '0;
                    attr_type_reg <= '0; attr_len_reg <= '0; cap_fields_reg <= '0;
                    cap_word_reg <= '0; reject_reg <= '0;
                end else begin
                    byte_offset_reg <= off_n; hdr_type_reg <= mt_n;
                    len_left_reg <= left_n; decl_len_reg <= dl_n;
                    txn_word_reg <= tw_n; attr_idx_reg <= idx_n;
                    attr_type_reg <= at_n; attr_len_reg <= al_n;
                    cap_fields_reg <= cf_n; cap_word_reg <= cw_n; reject_reg <= rj_n;
                end
            end
            if (accept) begin
                q_rd_reg <= 1'b0;
                q_count_reg <= 2'(attr_emit) + 2'(s_tlast);
            end else if (pop) begin
                q_rd_reg <= !q_rd_reg;
                q_count_reg <= q_count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            if (attr_emit) begin
                q_reg[0] <= attr_rec;
                q_reg[1] <= verd_rec;
            end else begin
                q_reg[0] <= verd_rec;
            end
        end
    end

    csmp_pkg::record_t head;
    assign head = q_reg[q_rd_reg];
    assign m_tdata = {{(144 - $bits(csmp_pkg::record_t) + 1){1'b0}},
                      head[$bits(csmp_pkg::record_t)-2:0]};
    assign m_tlast = head.last_of_run;

`ifndef SYNTHESIS
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg != 2'd3) else $error("queue overflow");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (q_count_reg == 2'd0 || pop)) else $error("ready with queue busy");
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && q_count_reg == 2'd1) |-> m_tlast) else $error("run end missing");
`endif
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench: classic STUN message parser, predicted records checked against the result stream.
`timescale 1ns / 100ps
module tb;
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic         m_tlast;

    classic_stun_message_parser uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    logic [8:0]          byte_q[$];      // {end_of_message, data_byte}
    csmp_pkg::record_t   record_q[$];
    logic [7:0]          msg_bytes[$];
    int          idle_mode = 0;
    int          errors = 0;
    int          n_bytes = 0;
    int          n_records = 0;
    int          n_msgs = 0;

    // parser state as predicted
    logic [16:0] msg_pos;
    logic [15:0] hdr_type, len_left, decl_len, tlv_idx, tlv_type, tlv_len;
    logic [31:0] txn_word, val_word, ip_bytes;
    logic [2:0]  status;

    task automatic clear_parse;
        msg_pos = '0; hdr_type = '0; len_left = '0; decl_len = '0; tlv_idx = '0;
        tlv_type = '0; tlv_len = '0; txn_word = '0; val_word = '0; ip_bytes = '0;
        status = csmp_pkg::VERDICT_OK;
    endtask

    function automatic csmp_pkg::record_t tlv_record(input logic bogus);
        csmp_pkg::record_t r;
        logic [5:0]  m;
        logic [7:0]  fam;
        logic [15:0] port;
        logic [31:0] ip;
        fam = val_word[23:16];
        port = val_word[15:0];
        ip = ip_bytes;
        m = '0;
        if (!bogus) begin
            case (tlv_type)
                16'h0001, 16'h0002, 16'h0004, 16'h0005, 16'h000b, 16'h000e,
                16'h0011, 16'h0012, csmp_pkg::XOR_MAPPED_TYPE: begin
                    m[0] = tlv_len >= 16'd2;
                    m[1] = tlv_len >= 16'd4;
                    m[2] = tlv_len >= 16'd8 && fam == 8'd1;
                end
                16'h0016: m[0] = tlv_len >= 16'd2;
                16'h0003, 16'h000d, 16'h000f, 16'h0010: m[3] = tlv_len >= 16'd4;
                16'h0009: begin
                    m[4] = tlv_len >= 16'd3;
                    m[5] = tlv_len >= 16'd4;
                end
                default: m = '0;
            endcase
        end
        if (tlv_type == csmp_pkg::XOR_MAPPED_TYPE) begin
            port = port ^ txn_word[31:16];
            ip = ip ^ txn_word;
        end
        r = '0;
        r.type_code = tlv_type;
        r.attr_len = tlv_len;
        r.addr_family = m[0] ? fam : 8'd0;
        r.port_clear = m[1] ? port : 16'd0;
        r.ipv4_clear = m[2] ? ip : 32'd0;
        r.word_value = m[3] ? val_word : 32'd0;
        r.err_class = m[4] ? val_word[10:8] : 3'd0;
        r.err_number = m[5] ? val_word[7:0] : 8'd0;
        r.present_mask = m;
        return r;
    endfunction

    function automatic logic classic_type(input logic [15:0] t);
        logic [15:0] known[16] = '{16'h0001, 16'h0101, 16'h0111, 16'h0002, 16'h0102,
            16'h0112, 16'h0003, 16'h0103, 16'h0113, 16'h0004, 16'h0104, 16'h0114,
            16'h0115, 16'h0006, 16'h0106, 16'h0116};
        foreach (known[i]) if (known[i] == t) return 1'b1;
        return 1'b0;
    endfunction

    task automatic walk_tlv(input logic [7:0] b, inout int n);
        logic [16:0] idx;
        logic [16:0] k;
        idx = {1'b0, tlv_idx};
        if (idx == 17'd0) begin
            if (len_left < 16'd4) begin
                status = csmp_pkg::VERDICT_BOGUS;
                return;
            end
            tlv_type = {b, 8'h00}; tlv_len = '0; val_word = '0; ip_bytes = '0;
        end else if (idx == 17'd1) begin
            tlv_type[7:0] = b;
        end else if (idx == 17'd2) begin
            tlv_len = {b, 8'h00};
        end else if (idx == 17'd3) begin
            tlv_len[7:0] = b;
            if (tlv_len >= len_left) begin
                record_q.push_back(tlv_record(1'b1));
                n++;
                status = csmp_pkg::VERDICT_BOGUS;
                tlv_idx = '0;
                return;
            end
        end else begin
            k = idx - 17'd4;
            if (k < 17'd4) val_word[8*(3-k) +: 8] = b;
            else if (k < 17'd8) ip_bytes[8*(7-k) +: 8] = b;
        end
        len_left = len_left - 16'd1;
        idx = idx + 17'd1;
        if (idx >= 17'd4 && idx == 17'd4 + {1'b0, tlv_len}) begin
            record_q.push_back(tlv_record(1'b0));
            n++;
            idx = '0;
        end
        tlv_idx = idx[15:0];
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic eom);
        int n;
        csmp_pkg::record_t v;
        n = 0;
        if (msg_pos < 17'(csmp_pkg::HDR_BYTES)) begin
            if (msg_pos < 17'd2) hdr_type = {hdr_type[7:0], b};
            else if (msg_pos < 17'd4) decl_len = {decl_len[7:0], b};
            else if (msg_pos < 17'd8) txn_word = {txn_word[23:0], b};
            if (msg_pos == 17'(csmp_pkg::HDR_BYTES - 1)) begin
                if ((hdr_type & csmp_pkg::TYPE_TOP_BITS) != 16'd0 ||
                    txn_word == csmp_pkg::NEW_STUN_COOKIE ||
                    txn_word == csmp_pkg::XMCP_COOKIE)
                    status = csmp_pkg::VERDICT_NOT_CLS;
                else if (!classic_type(hdr_type))
                    status = csmp_pkg::VERDICT_UNKNOWN;
                len_left = decl_len;
            end
        end else if (status == csmp_pkg::VERDICT_OK && len_left > 16'd0) begin
            walk_tlv(b, n);
        end
        if (msg_pos < csmp_pkg::OFFSET_LIMIT) msg_pos = msg_pos + 17'd1;
        if (eom) begin
            v = '0;
            v.record_kind = 1'b1;
            v.type_code = hdr_type;
            if (msg_pos < 17'(csmp_pkg::HDR_BYTES)) v.verdict = csmp_pkg::VERDICT_SHORT;
            else if (status == csmp_pkg::VERDICT_NOT_CLS ||
                     status == csmp_pkg::VERDICT_UNKNOWN) v.verdict = status;
            else if (msg_pos != 17'(csmp_pkg::HDR_BYTES) + {1'b0, decl_len})
                v.verdict = csmp_pkg::VERDICT_LEN_MISM;
            else v.verdict = status;
            record_q.push_back(v);
            n++;
            clear_parse();
        end
        if (n > 0) record_q[record_q.size() - 1].last_of_run = 1'b1;
    endtask

    // stimulus generation
    function automatic int sender_idle_pct();
        return (idle_mode == 1) ? 60 : (idle_mode == 3) ? 28 : 0;
    endfunction

    function automatic int receiver_stall_pct();
        return (idle_mode == 2) ? 60 : (idle_mode == 3) ? 28 : 0;
    endfunction

    task automatic push16(input logic [15:0] v);
        msg_bytes.push_back(v[15:8]);
        msg_bytes.push_back(v[7:0]);
    endtask

    task automatic send_msg;
        foreach (msg_bytes[i]) byte_q.push_back({i == msg_bytes.size() - 1, msg_bytes[i]});
        msg_bytes.delete();
        n_msgs++;
    endtask

    // style: 0 good, 1 not classic, 2 unknown type, 3 length mismatch,
    // 4 bogus attribute, 5 short, 6 truncated attribute header, 7 noise
    task automatic gen_msg(input int style, input int sub);
        logic [15:0] attr_types[16] = '{16'h0001, 16'h0002, 16'h0004, 16'h0005, 16'h000b,
            16'h000e, 16'h0011, 16'h0012, csmp_pkg::XOR_MAPPED_TYPE, 16'h0016, 16'h0003,
            16'h000d, 16'h000f, 16'h0010, 16'h0009, 16'h0000};
        logic [15:0] known[16] = '{16'h0001, 16'h0101, 16'h0111, 16'h0002, 16'h0102,
            16'h0112, 16'h0003, 16'h0103, 16'h0113, 16'h0004, 16'h0104, 16'h0114,
            16'h0115, 16'h0006, 16'h0106, 16'h0116};
        logic [7:0]  body[$];
        logic [15:0] t, l, mt;
        logic [31:0] tw;
        int na, len;
        body.delete();
        if (style == 7 || style == 5) begin
            len = (style == 5) ? $urandom_range(1, 19) : $urandom_range(1, 40);
            repeat (len) msg_bytes.push_back(8'($urandom));
            send_msg();
            return;
        end
        na = $urandom_range(0, 3);
        repeat (na) begin
            t = ($urandom_range(7) == 0) ? 16'($urandom) : attr_types[$urandom_range(15)];
            len = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
            body.push_back(t[15:8]); body.push_back(t[7:0]);
            body.push_back(8'd0); body.push_back(len[7:0]);
            for (int j = 0; j < len; j++) begin
                if (j == 1) body.push_back(($urandom_range(3) != 0) ? 8'($urandom_range(1, 2))
                                                                     : 8'($urandom));
                else body.push_back(8'($urandom));
            end
        end
        if (style == 4) begin
            t = attr_types[$urandom_range(15)];
            l = ($urandom_range(1)) ? 16'hFFFF : 16'($urandom_range(1, 30));
            body.push_back(t[15:8]); body.push_back(t[7:0]);
            body.push_back(l[15:8]); body.push_back(l[7:0]);
            repeat ($urandom_range(0, 3)) body.push_back(8'($urandom));
        end
        if (style == 6) repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        mt = known[$urandom_range(15)];
        tw = $urandom;
        if (style == 1) begin
            case (sub % 3)
                0: tw = csmp_pkg::NEW_STUN_COOKIE;
                1: tw = csmp_pkg::XMCP_COOKIE;
                default: mt = mt | (16'($urandom_range(1, 3)) << 14);
            endcase
        end
        if (style == 2) begin
            mt = 16'($urandom) & 16'h3FFF;
            if (classic_type(mt)) mt = 16'h0005;
        end
        if (sub == 99) mt = 16'h0112;
        l = 16'(body.size());
        if (style == 3) l = (sub % 2) ? l + 16'($urandom_range(1, 8))
                                      : l - 16'($urandom_range(0, 3)) - 16'd1;
        push16(mt); push16(l);
        push16(tw[31:16]); push16(tw[15:0]);
        repeat (12) msg_bytes.push_back(8'($urandom));
        foreach (body[i]) msg_bytes.push_back(body[i]);
        if (style == 3 && (sub % 2) == 0)
            repeat ($urandom_range(1, 5)) msg_bytes.push_back(8'($urandom));
        send_msg();
    endtask

    task automatic wait_drained;
        while (byte_q.size() != 0 || s_tvalid || record_q.size() != 0) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, e, a);
            errors++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(99) >= receiver_stall_pct();
            if (!s_tvalid || s_tready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
                    s_tvalid <= 1'b1;
                    {s_tlast, s_tdata} <= byte_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and predictor
    always @(posedge aclk) begin
        csmp_pkg::record_t e, a;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                parse_byte(s_tdata, s_tlast);
                n_bytes++;
            end
            if (m_tvalid && m_tready) begin
                a = {m_tlast, m_tdata[140:0]};
                n_records++;
                if (record_q.size() == 0) begin
                    $display("%0t: unexpected record, expected none, got %h", $time, a);
                    errors++;
                end else begin
                    e = record_q.pop_front();
                    check_field("record_kind", 32'(e.record_kind), 32'(a.record_kind));
                    check_field("type_code", 32'(e.type_code), 32'(a.type_code));
                    check_field("attr_len", 32'(e.attr_len), 32'(a.attr_len));
                    check_field("addr_family", 32'(e.addr_family), 32'(a.addr_family));
                    check_field("port_clear", 32'(e.port_clear), 32'(a.port_clear));
                    check_field("ipv4_clear", e.ipv4_clear, a.ipv4_clear);
                    check_field("word_value", e.word_value, a.word_value);
                    check_field("err_class", 32'(e.err_class), 32'(a.err_class));
                    check_field("err_number", 32'(e.err_number), 32'(a.err_number));
                    check_field("present_mask", 32'(e.present_mask), 32'(a.present_mask));
                    check_field("verdict", 32'(e.verdict), 32'(a.verdict));
                    check_field("last_of_run", 32'(e.last_of_run), 32'(a.last_of_run));
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int r, style;
        clear_parse();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        // directed
        for (int s = 0; s < 8; s++) gen_msg(s, 0);
        gen_msg(1, 1); gen_msg(1, 2); gen_msg(3, 1); gen_msg(4, 0); gen_msg(0, 99);
        wait_drained();
        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = ph;
            repeat (2) begin
                r = $urandom_range(99);
                style = (r < 60) ? 0 : 1 + (r % 7);
                gen_msg(style, $urandom_range(3));
            end
            wait_drained();   // sender holds off until all records are back
            gen_msg(($urandom_range(3) == 0) ? $urandom_range(1, 7) : 0, $urandom_range(3));
            wait_drained();
        end
        repeat (50) @(posedge aclk);
        $display("Covered %0d messages, %0d bytes, %0d records under four idle patterns,",
                 n_msgs, n_bytes, n_records);
        $display("including every verdict, bogus and truncated attributes and noise.");
        if (errors == 0 && record_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
